### src/row_softmax_top_defines.svh
// ----------------------------------------------------------------------------
// Row softmax assertion macros
// Shared property shorthands for the checker of the row softmax block.
// ----------------------------------------------------------------------------
`ifndef ROW_SOFTMAX_TOP_DEFINES_SVH
`define ROW_SOFTMAX_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low.
`define RSM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, quiet while rst_n is low.
`define RSM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/rsm_pkg.sv
// ----------------------------------------------------------------------------
// Row softmax package
// Fixed-point constants shared by the row softmax modules.
// ----------------------------------------------------------------------------
package rsm_pkg;

    localparam int LOGIT_W = 16;
    localparam int EXP_W   = 17;
    localparam int SUM_W   = 23;
    localparam int QUO_W   = 33;

    // log2(e) in Q1.16 and the quadratic coefficients for 2^-f.
    localparam logic [16:0] LOG2E_Q16 = 17'd94548;
    localparam logic [16:0] POLY_C1   = 17'd43024;
    localparam logic [16:0] POLY_C2   = 17'd10256;

endpackage

### src/row_softmax_top.sv
// ----------------------------------------------------------------------------
// Row softmax top level
// Streaming fixed-point softmax over rows of Q8.8 logits, built around one
// shared multiplier and a small sequencer.
// ----------------------------------------------------------------------------
//
//   Channel   Signals                         Payload
//   --------  ------------------------------  -------------------------------
//   input     in_valid / in_ready             logit (signed Q8.8)
//   output    out_valid / out_ready           probability (Q0.16), row_end
//   config    cfg_we                          cfg_wdata (row_length)
//
// A logit request is taken while the block is idle. The request that
// completes a row of n logits starts the row pass: per entry a RAM read,
// four uses of the shared multiplier and a write for the exponentials, then
// the bit-serial reciprocal, then per entry a RAM read, a multiply and a
// rounding for the probabilities. A stalled output request holds the
// sequencer in place. Reset clears the control state at once; no clearing
// pass is run.
//
module row_softmax_top #(
    parameter int MAX_ROW = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] logit,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] probability,
    output logic        row_end,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata
);

    localparam int IW = $clog2(MAX_ROW);
    localparam int CW = $clog2(MAX_ROW + 1);

    // Sequencer states.
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_EXP_RD   = 4'd1;
    localparam logic [3:0] S_EXP_M1   = 4'd2;
    localparam logic [3:0] S_EXP_M2   = 4'd3;
    localparam logic [3:0] S_EXP_M3   = 4'd4;
    localparam logic [3:0] S_EXP_M4   = 4'd5;
    localparam logic [3:0] S_EXP_WR   = 4'd6;
    localparam logic [3:0] S_DIV_GO   = 4'd7;
    localparam logic [3:0] S_DIV_WAIT = 4'd8;
    localparam logic [3:0] S_OUT_RD   = 4'd9;
    localparam logic [3:0] S_OUT_MUL  = 4'd10;
    localparam logic [3:0] S_OUT_SH   = 4'd11;
    localparam logic [3:0] S_OUT_WAIT = 4'd12;

    logic [3:0]                         state_reg,   state_next;
    logic [6:0]                         rlen_reg,    rlen_next;
    logic [CW-1:0]                      fill_reg,    fill_next;
    logic signed [15:0]                 max_reg,     max_next;
    logic [IW-1:0]                      idx_reg,     idx_next;
    logic [IW-1:0]                      last_reg,    last_next;
    logic [rsm_pkg::SUM_W-1:0]          sum_reg,     sum_next;
    logic [48:0]                        prod_reg,    prod_next;
    logic [15:0]                        f_reg,       f_next;
    logic [9:0]                         sh_reg,      sh_next;
    logic [15:0]                        term_reg,    term_next;
    logic [31:0]                        recip_reg,   recip_next;
    logic [15:0]                        prob_reg,    prob_next;
    logic                               rend_reg,    rend_next;
    logic                               ovalid_reg,  ovalid_next;

    logic [6:0]                         eff_len;
    logic [CW-1:0]                      fill_inc;
    logic [15:0]                        row_rdata;
    logic [rsm_pkg::EXP_W-1:0]          exp_rdata;
    logic                               exp_we;
    logic [rsm_pkg::EXP_W-1:0]          exp_val;
    logic                               div_start;
    logic                               div_done;
    logic [rsm_pkg::QUO_W-1:0]          div_quo;
    logic [31:0]                        mul_a;
    logic [16:0]                        mul_b;
    logic [48:0]                        mul_p;
    logic [16:0]                        t_diff;
    logic [33:0]                        u_sum;
    logic [17:0]                        poly_p;
    logic [48:0]                        round_p;
    logic                               in_acc;
    logic                               out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = ovalid_reg && out_ready;

    // A zero length means one logit; lengths past the storage are clipped.
    always_comb
    begin
        if (rlen_reg == 7'd0)
        begin
            eff_len = 7'd1;
        end
        else if (rlen_reg > 7'(MAX_ROW))
        begin
            eff_len = 7'(MAX_ROW);
        end
        else
        begin
            eff_len = rlen_reg;
        end
    end

    assign fill_inc = fill_reg + 1'b1;

    // Row and exponential storage.
    rsm_ram #(.WIDTH(rsm_pkg::LOGIT_W), .DEPTH(MAX_ROW)) u_row_ram (
        .clk   (clk),
        .we    (in_acc),
        .waddr (fill_reg[IW-1:0]),
        .wdata (logit),
        .raddr (idx_reg),
        .rdata (row_rdata)
    );

    rsm_ram #(.WIDTH(rsm_pkg::EXP_W), .DEPTH(MAX_ROW)) u_exp_ram (
        .clk   (clk),
        .we    (exp_we),
        .waddr (idx_reg),
        .wdata (exp_val),
        .raddr (idx_reg),
        .rdata (exp_rdata)
    );

    rsm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .divisor  (sum_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Distance below the row maximum, never negative.
    assign t_diff = {max_reg[15], max_reg} - {row_rdata[15], row_rdata};

    // u = round(t * log2(e)) in Q.16; its integer part is the shift count.
    assign u_sum = {1'b0, prod_reg[32:0]} + 34'd128;

    // 2^-f = 1 - c1*f + c2*f^2, then scaled by 2^-n.
    assign poly_p = 18'd65536 - 18'(prod_reg[31:16]) + 18'(term_reg);
    assign exp_val = (sh_reg > 10'd16) ? '0
                                       : rsm_pkg::EXP_W'(poly_p >> sh_reg[4:0]);

    assign round_p = prod_reg + 49'd32768;

    // The shared multiplier: its operands follow the sequencer step.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_EXP_M1:
            begin
                mul_a = {16'd0, t_diff[15:0]};
                mul_b = rsm_pkg::LOG2E_Q16;
            end
            S_EXP_M2:
            begin
                mul_a = {16'd0, u_sum[23:8]};
                mul_b = {1'b0, u_sum[23:8]};
            end
            S_EXP_M3:
            begin
                mul_a = prod_reg[31:0];
                mul_b = rsm_pkg::POLY_C2;
            end
            S_EXP_M4:
            begin
                mul_a = {16'd0, f_reg};
                mul_b = rsm_pkg::POLY_C1;
            end
            S_OUT_MUL:
            begin
                mul_a = recip_reg;
                mul_b = exp_rdata;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        state_next  = state_reg;
        rlen_next   = cfg_we ? cfg_wdata : rlen_reg;
        fill_next   = fill_reg;
        max_next    = max_reg;
        idx_next    = idx_reg;
        last_next   = last_reg;
        sum_next    = sum_reg;
        prod_next   = prod_reg;
        f_next      = f_reg;
        sh_next     = sh_reg;
        term_next   = term_reg;
        recip_next  = recip_reg;
        prob_next   = prob_reg;
        rend_next   = rend_reg;
        ovalid_next = ovalid_reg;
        exp_we      = 1'b0;
        div_start   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    fill_next = fill_inc;
                    if ($signed(logit) > max_reg)
                    begin
                        max_next = $signed(logit);
                    end
                    if (7'(fill_inc) >= eff_len)
                    begin
                        last_next  = fill_reg[IW-1:0];
                        idx_next   = '0;
                        sum_next   = '0;
                        state_next = S_EXP_RD;
                    end
                end
            end
            S_EXP_RD:
            begin
                state_next = S_EXP_M1;
            end
            S_EXP_M1:
            begin
                prod_next  = mul_p;
                state_next = S_EXP_M2;
            end
            S_EXP_M2:
            begin
                f_next     = u_sum[23:8];
                sh_next    = u_sum[33:24];
                prod_next  = mul_p;
                state_next = S_EXP_M3;
            end
            S_EXP_M3:
            begin
                prod_next  = mul_p;
                state_next = S_EXP_M4;
            end
            S_EXP_M4:
            begin
                term_next  = prod_reg[47:32];
                prod_next  = mul_p;
                state_next = S_EXP_WR;
            end
            S_EXP_WR:
            begin
                exp_we   = 1'b1;
                sum_next = sum_reg + rsm_pkg::SUM_W'(exp_val);
                if (idx_reg == last_reg)
                begin
                    state_next = S_DIV_GO;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_EXP_RD;
                end
            end
            S_DIV_GO:
            begin
                div_start  = 1'b1;
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (div_done)
                begin
                    recip_next = div_quo[31:0];
                    idx_next   = '0;
                    state_next = S_OUT_RD;
                end
            end
            S_OUT_RD:
            begin
                state_next = S_OUT_MUL;
            end
            S_OUT_MUL:
            begin
                prod_next  = mul_p;
                state_next = S_OUT_SH;
            end
            S_OUT_SH:
            begin
                prob_next   = (|round_p[48:32]) ? 16'hFFFF : round_p[31:16];
                rend_next   = (idx_reg == last_reg);
                ovalid_next = 1'b1;
                state_next  = S_OUT_WAIT;
            end
            S_OUT_WAIT:
            begin
                if (out_acc)
                begin
                    ovalid_next = 1'b0;
                    if (idx_reg == last_reg)
                    begin
                        fill_next  = '0;
                        max_next   = -16'sd32768;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_OUT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            rlen_reg   <= 7'd64;
            fill_reg   <= '0;
            max_reg    <= -16'sd32768;
            idx_reg    <= '0;
            last_reg   <= '0;
            sum_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rlen_reg   <= rlen_next;
            fill_reg   <= fill_next;
            max_reg    <= max_next;
            idx_reg    <= idx_next;
            last_reg   <= last_next;
            sum_reg    <= sum_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Datapath registers carry no reset.
    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        f_reg     <= f_next;
        sh_reg    <= sh_next;
        term_reg  <= term_next;
        recip_reg <= recip_next;
        prob_reg  <= prob_next;
        rend_reg  <= rend_next;
    end

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = ovalid_reg;
    assign probability = prob_reg;
    assign row_end     = rend_reg;

endmodule

### src/rsm_ram.sv
// ----------------------------------------------------------------------------
// Row softmax RAM
// Generic one-write, one-read memory with a registered read port.
// ----------------------------------------------------------------------------
module rsm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### src/rsm_div.sv
// ----------------------------------------------------------------------------
// Row softmax reciprocal divider
// Restoring divider that forms 2^32 / divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rsm_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [rsm_pkg::SUM_W-1:0]  divisor,
    output logic                       done,
    output logic [rsm_pkg::QUO_W-1:0]  quotient
);

    localparam int CNT_W = $clog2(rsm_pkg::QUO_W);

    logic                       run_reg,  run_next;
    logic                       done_reg, done_next;
    logic [CNT_W-1:0]           cnt_reg,  cnt_next;
    logic [rsm_pkg::SUM_W-1:0]  rem_reg,  rem_next;
    logic [rsm_pkg::QUO_W-1:0]  quo_reg,  quo_next;
    logic [rsm_pkg::SUM_W:0]    rem_sh;
    logic                       dbit;
    logic                       fits;

    // The dividend is 2^32: only its top bit is set.
    assign dbit   = (cnt_reg == CNT_W'(rsm_pkg::QUO_W - 1));
    assign rem_sh = {rem_reg, dbit};
    assign fits   = (rem_sh >= {1'b0, divisor});

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = CNT_W'(rsm_pkg::QUO_W - 1);
            rem_next = '0;
            quo_next = '0;
        end
        else if (run_reg)
        begin
            rem_next = fits ? rsm_pkg::SUM_W'(rem_sh - {1'b0, divisor})
                            : rsm_pkg::SUM_W'(rem_sh);
            quo_next = {quo_reg[rsm_pkg::QUO_W-2:0], fits};
            if (cnt_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### src/rsm_chk.sv
// ----------------------------------------------------------------------------
// Row softmax port checker
// Watches the top-level ports over time; bound to the top level below.
// ----------------------------------------------------------------------------
`include "row_softmax_top_defines.svh"

module rsm_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] probability,
    input logic        row_end
);

    `RSM_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(probability) && $stable(row_end), "stalled result changed")
    `RSM_ASSERT_IMP(a_one_side, out_valid, !in_ready, "input taken while a result is pending")
    `RSM_ASSERT_NXT(a_row_done, out_valid && out_ready && row_end, in_ready && !out_valid, "block not idle after the last result of a row")
    `RSM_ASSERT_NXT(a_no_early, in_valid && in_ready, !out_valid, "result appeared right after an input request")

endmodule

bind row_softmax_top rsm_chk u_rsm_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .probability (probability),
    .row_end     (row_end)
);

### dv/row_softmax_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Row softmax top level testbench
// Streams signed Q8.8 logit requests through the row softmax block under a
// range of row lengths and idling patterns, and checks every probability and
// row_end flag against a cycle-free model of the fixed-point softmax.
// ----------------------------------------------------------------------------
module row_softmax_top_test;

    localparam int MAX_ROW      = 64;
    localparam int DRAIN_CYCLES = 10 * MAX_ROW + 100;
    localparam int STALL_LIMIT  = 20000;

    // Idling modes of the random phases: no side, the sender, the receiver or both idle.
    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    typedef struct packed {
        logic [15:0] probability;
        logic        row_end;
    } prob_item_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [15:0] logit;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] probability;
    logic        row_end;
    logic        cfg_we;
    logic [6:0]  cfg_wdata;

    row_softmax_top #(.MAX_ROW(MAX_ROW)) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .logit       (logit),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .probability (probability),
        .row_end     (row_end),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata)
    );

    // Stimulus waiting for the driver, and probabilities waiting for the DUT.
    logic [15:0] logit_queue[$];
    prob_item_t  prob_queue[$];

    // Predictor copy of the block state.
    logic signed [15:0] row_buf[MAX_ROW];
    int unsigned        row_fill;
    logic signed [15:0] row_peak;
    logic [6:0]         row_len_reg;

    // Handshake seen at the last rising edge, so the driver knows to advance.
    logic        in_ready_seen;

    idle_mode_t  idle_mode;
    bit          recv_hold;
    int          fail_count;
    int          sent_count;
    int          prob_count;
    int          row_count;
    int          quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // exp(-t) for t in Q8.8, returned in unsigned Q1.16.
    function automatic logic [16:0] exp_neg_q16(input logic [15:0] t);
        logic [63:0] u;
        logic [63:0] n;
        logic [63:0] f;
        logic [63:0] p;
        begin
            u = (64'(t) * 64'd94548 + 64'd128) >> 8;
            n = u >> 16;
            f = u & 64'hFFFF;
            if (n > 16)
                return 17'd0;
            p = 64'd65536 - ((64'd43024 * f) >> 16) + ((64'd10256 * f * f) >> 32);
            return 17'(p >> n);
        end
    endfunction

    // Takes one accepted logit; when it closes a row, queues the whole row.
    task automatic predict_logit(input logic [15:0] value);
        int unsigned eff_len;
        logic [16:0] exps[MAX_ROW];
        logic [22:0] sum;
        logic [31:0] recip;
        logic [63:0] p;
        prob_item_t  item;
        begin
            eff_len = row_len_reg;
            if (eff_len == 0)
                eff_len = 1;
            if (eff_len > MAX_ROW)
                eff_len = MAX_ROW;
            if (row_fill >= MAX_ROW)
                row_fill = 0;
            row_buf[row_fill] = value;
            if ($signed(value) > row_peak)
                row_peak = value;
            row_fill++;
            if (row_fill >= eff_len)
            begin
                sum = '0;
                for (int i = 0; i < row_fill; i++)
                begin
                    exps[i] = exp_neg_q16(16'(32'(row_peak) - 32'(row_buf[i])));
                    sum = sum + 23'(exps[i]);
                end
                recip = (sum == 0) ? 32'hFFFF_FFFF : 32'(64'h1_0000_0000 / 64'(sum));
                for (int i = 0; i < row_fill; i++)
                begin
                    p = (64'(exps[i]) * 64'(recip) + 64'd32768) >> 16;
                    item.probability = (p > 64'd65535) ? 16'hFFFF : p[15:0];
                    item.row_end     = (i + 1 == row_fill);
                    prob_queue.push_back(item);
                end
                row_fill = 0;
                row_peak = 16'sh8000;
                row_count++;
            end
        end
    endtask

    // Driver: requests change on the falling edge only.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_ready_seen)
            begin
                if (logit_queue.size() != 0 &&
                    !((idle_mode == IDLE_SEND || idle_mode == IDLE_BOTH) &&
                      $urandom_range(99) < ((idle_mode == IDLE_SEND) ? 84 : 26)))
                begin
                    in_valid <= 1'b1;
                    logit    <= logit_queue.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                    logit    <= 16'($urandom);
                end
            end
            if (recv_hold)
                out_ready <= 1'b0;
            else if (idle_mode == IDLE_RECV)
                out_ready <= ($urandom_range(99) >= 84);
            else if (idle_mode == IDLE_BOTH)
                out_ready <= ($urandom_range(99) >= 26);
            else
                out_ready <= 1'b1;
        end
    end

    // Monitor: samples both handshakes on the rising edge.
    always @(posedge clk)
    begin
        in_ready_seen <= rst_n && in_valid && in_ready;
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (in_valid && in_ready)
            begin
                predict_logit(logit);
                sent_count <= sent_count + 1;
            end
            if (out_valid && out_ready)
            begin
                prob_count <= prob_count + 1;
                if (prob_queue.size() == 0)
                begin
                    $display("%0t: unexpected probability %0d row_end %0d",
                             $time, probability, row_end);
                    fail_count++;
                end
                else
                begin
                    if (prob_queue[0].probability !== probability)
                    begin
                        $display("%0t: probability expected %0d actual %0d",
                                 $time, prob_queue[0].probability, probability);
                        fail_count++;
                    end
                    if (prob_queue[0].row_end !== row_end)
                    begin
                        $display("%0t: row_end expected %0d actual %0d",
                                 $time, prob_queue[0].row_end, row_end);
                        fail_count++;
                    end
                    void'(prob_queue.pop_front());
                end
            end
        end
    end

    // Watchdog on cycles with no accepted request on either side.
    always @(posedge clk)
    begin
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
            $display("row_softmax_top test failed");
            $finish;
        end
    end

    // Waits until all queued logits are taken and every probability has come.
    task automatic wait_idle();
        begin
            while (logit_queue.size() != 0 || in_valid || prob_queue.size() != 0)
                @(posedge clk);
            repeat (DRAIN_CYCLES) @(posedge clk);
        end
    endtask

    // Register write between phases, on the falling edge.
    task automatic write_row_length(input logic [6:0] value);
        begin
            @(negedge clk);
            cfg_we    <= 1'b1;
            cfg_wdata <= value;
            @(negedge clk);
            cfg_we    <= 1'b0;
            row_len_reg = value;
        end
    endtask

    // Random logits; some runs of eight cluster near a base so the exponentials spread.
    task automatic queue_random(input int count);
        logic [15:0] base;
        begin
            base = 16'($urandom);
            for (int i = 0; i < count; i++)
            begin
                if (i % 8 == 0)
                    base = 16'($urandom);
                case ($urandom_range(3))
                    0: logit_queue.push_back(16'($urandom));
                    1: logit_queue.push_back(base + 16'($urandom_range(2047)) - 16'd1024);
                    2: logit_queue.push_back(base + 16'($urandom_range(255)));
                    default: logit_queue.push_back(
                        $urandom_range(1) ? 16'h7FFF - 16'($urandom_range(3))
                                          : 16'h8000 + 16'($urandom_range(3)));
                endcase
            end
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        logit        = '0;
        out_ready    = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        idle_mode    = IDLE_NONE;
        recv_hold    = 1'b0;
        fail_count   = 0;
        sent_count   = 0;
        prob_count   = 0;
        row_count    = 0;
        quiet_cycles = 0;
        row_fill     = 0;
        row_peak     = 16'sh8000;
        row_len_reg  = 7'd64;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: single-entry rows at the field extremes, then pairs, one of
        // them far apart so the small exponential underflows to zero.
        write_row_length(7'd1);
        logit_queue.push_back(16'h8000);
        logit_queue.push_back(16'h7FFF);
        logit_queue.push_back(16'h0000);
        wait_idle();
        write_row_length(7'd0);   // A zero length acts as one.
        logit_queue.push_back(16'hFFFF);
        wait_idle();
        write_row_length(7'd2);
        logit_queue.push_back(16'h7FFF);
        logit_queue.push_back(16'h8000);
        logit_queue.push_back(16'h0100);
        logit_queue.push_back(16'h0100);   // Equal entries split evenly.
        logit_queue.push_back(16'h0000);
        logit_queue.push_back(16'h00B1);   // Just under one in base two.
        wait_idle();
        write_row_length(7'd127); // Above the maximum acts as the maximum.
        for (int i = 0; i < MAX_ROW; i++)
            logit_queue.push_back(16'(i * 97));
        wait_idle();

        // A length shortened in mid-row closes the row with the next request, holding every entry taken so far.
        write_row_length(7'd8);
        for (int i = 0; i < 5; i++)
            logit_queue.push_back(16'(i << 8));
        while (logit_queue.size() != 0 || in_valid)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        write_row_length(7'd3);
        logit_queue.push_back(16'h0300);
        wait_idle();

        // Random phases under each idling pattern and several lengths.
        for (int ph = 0; ph < 8; ph++)
        begin
            idle_mode = idle_mode_t'(ph % 4);
            case (ph)
                0: write_row_length(7'd4);
                1: write_row_length(7'd1);
                2: write_row_length(7'd64);
                3: write_row_length(7'd7);
                4: write_row_length(7'($urandom_range(1, 16)));
                5: write_row_length(7'd2);
                6: write_row_length(7'($urandom_range(17, 63)));
                default: write_row_length(7'd5);
            endcase
            queue_random(ph == 2 ? 64 : 12);
            if (ph == 0)
            begin
                // Long receiver hold-off while requests keep coming.
                recv_hold = 1'b1;
                repeat (400) @(posedge clk);
                recv_hold = 1'b0;
            end
            while (logit_queue.size() != 0 || in_valid)
                @(posedge clk);
            idle_mode = IDLE_NONE;
            // Finish any partial row so no entries carry over.
            while (row_fill != 0)
            begin
                logit_queue.push_back(16'($urandom));
                while (logit_queue.size() != 0 || in_valid)
                    @(posedge clk);
            end
            wait_idle();
        end

        $display("Sent %0d logit requests, checked %0d probabilities in %0d rows.",
                 sent_count, prob_count, row_count);
        $display("Lengths from zero to 127 and all idling patterns were covered.");
        if (fail_count == 0)
            $display("row_softmax_top test passed");
        else
            $display("row_softmax_top test failed");
        $finish;
    end

endmodule
